FILE: rtl/insertion_sort_engine_macros.svh
// Assertion macros shared by the insertion sort engine modules.
`ifndef INSERTION_SORT_ENGINE_MACROS_SVH
`define INSERTION_SORT_ENGINE_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ISE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ise assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ISE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ise assertion failed");
`else
`define ISE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ISE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ise_pkg.sv
// Package with the types and constants of the insertion sort engine.
package ise_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic last_one;
        logic full;
    } t_dp_sts;

endpackage

FILE: rtl/ise_intf.sv
// Handshake interfaces for the key input and the sorted result output.
interface ise_in_if import ise_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] key;
    logic                     last;

    modport source (output valid, output key, output last, input ready);
    modport sink (input valid, input key, input last, output ready);
endinterface

interface ise_out_if import ise_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_key;
    logic                     final_res;
    logic                     overflow;

    modport source (output valid, output sorted_key, output final_res, output overflow,
                    input ready);
    modport sink (input valid, input sorted_key, input final_res, input overflow,
                  output ready);
endinterface

FILE: rtl/ise_datapath.sv
// Datapath: a row of sorted cells with parallel compare-and-shift insertion and pop.
`include "insertion_sort_engine_macros.svh"

module ise_datapath import ise_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_key,
    output t_dp_sts                  o_sts,
    output logic signed [DATA_W-1:0] o_sorted_key,
    output logic                     o_final_res,
    output logic                     o_overflow
);

    logic signed [DATA_W-1:0] r_cell [CAPACITY];
    logic signed [DATA_W-1:0] n_cell [CAPACITY];
    logic signed [DATA_W-1:0] up_val [CAPACITY];
    logic signed [DATA_W-1:0] dn_val [CAPACITY];
    logic [CAPACITY-1:0]      gt;
    logic [CAPACITY-1:0]      up_gt;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_dropped;
    logic                     n_dropped;
    logic                     full;
    logic                     last_one;

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign last_one = (r_count == CNT_W'(1));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign gt[g] = (CNT_W'(g) < r_count) && (r_cell[g] > i_key);
        if (g == 0) begin : g_first
            assign up_gt[g]  = 1'b0;
            assign up_val[g] = i_key;
        end else begin : g_rest
            assign up_gt[g]  = gt[g-1];
            assign up_val[g] = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign dn_val[g] = r_cell[g];
        end else begin : g_below
            assign dn_val[g] = r_cell[g+1];
        end
    end

    // A cell takes the key or its lower neighbor when it holds a larger entry
    // or is the first free cell; larger entries thus move up by one place.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.insert && !full && (gt[i] || (CNT_W'(i) == r_count))) begin
                n_cell[i] = up_gt[i] ? up_val[i] : i_key;
            end else if (i_cmd.pop) begin
                n_cell[i] = dn_val[i];
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (i_cmd.insert) begin
            if (full) begin
                n_dropped = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
            if (last_one) begin
                n_dropped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    assign o_sts.last_one = last_one;
    assign o_sts.full     = full;
    assign o_sorted_key   = r_cell[0];
    assign o_final_res    = last_one;
    assign o_overflow     = r_dropped;

    `ISE_ASSERT_NOW(a_cmd_excl, i_clk, i_rst_n, i_cmd.insert, !i_cmd.pop)
    `ISE_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_count != '0)
    `ISE_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_cmd.insert && !full,
        r_count == $past(r_count) + CNT_W'(1))
    `ISE_ASSERT_NEXT(a_set_closed, i_clk, i_rst_n, i_cmd.pop && last_one,
        (r_count == '0) && !r_dropped)
    `ISE_ASSERT_NOW(a_head_ordered, i_clk, i_rst_n, r_count > CNT_W'(1),
        !(r_cell[1] < r_cell[0]))

endmodule

FILE: rtl/ise_controller.sv
// Controller: state machine that sequences key loading and sorted emission.
`include "insertion_sort_engine_macros.svh"

module ise_controller import ise_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.pop    = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.insert = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.last_one) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    `ISE_ASSERT_NOW(a_no_in_during_emit, i_clk, i_rst_n, r_state == ST_EMIT, !o_in_ready)
    `ISE_ASSERT_NEXT(a_last_starts_emit, i_clk, i_rst_n, o_cmd.insert && i_in_last,
        r_state == ST_EMIT)
    `ISE_ASSERT_NEXT(a_final_ends_emit, i_clk, i_rst_n, o_cmd.pop && i_sts.last_one,
        r_state == ST_LOAD)

endmodule

FILE: rtl/insertion_sort_engine.sv
// Insertion sort engine top level: stable ascending sort of signed Q16.16 keys.
// Keys may arrive every cycle while loading; a key is inserted unless the row is full.
// After the last key is inserted, the first result is valid on the next cycle, and one
// result leaves per cycle while the sink is ready; input is held off for those results.
// Insertion compares the key against every cell of the row at once and shifts in parallel.
// Reset clears the fill count, the overflow flag and the state; cell contents stay as they are.
module insertion_sort_engine import ise_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ise_in_if.sink    i_in,
    ise_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ise_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    ise_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key        (i_in.key),
        .o_sts        (sts),
        .o_sorted_key (o_out.sorted_key),
        .o_final_res  (o_out.final_res),
        .o_overflow   (o_out.overflow)
    );

endmodule
